### design/spgm_pkg.sv
// Shared types and constants of the stereo pan gain mixer.
package spgm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  // Largest scaled magnitude after four gain stages, each gain below 2^16.
  localparam int MAG_W    = 20;
  localparam int PROD_W   = MAG_W + GAIN_W;

  localparam logic [GAIN_W-1:0] MASTER_GAIN_RESET = 16'd16384;
  localparam logic [63:0]       HALF_PI_Q30       = 64'd1686629713;
  localparam logic [15:0]       PAN_GAIN_MAX      = 16'd32768;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       sample_present;
    logic [GAIN_W-1:0]          source_gain;
    logic [GAIN_W-1:0]          source_volume;
    logic signed [SAMPLE_W-1:0] pan_position;
    logic                       source_muted;
    logic                       last_source;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic signed [SAMPLE_W-1:0] mono_downmix;
  } out_item_t;

  typedef enum logic {
    CH_LEFT,
    CH_RIGHT
  } chan_t;

  typedef enum logic [1:0] {
    STEP_PAN,
    STEP_SRC,
    STEP_VOL,
    STEP_MST
  } mul_step_t;

  typedef struct packed {
    logic      load_item;
    logic      calc_idx;
    logic      rd_en;
    chan_t     chan;
    logic      mul_en;
    mul_step_t mul_step;
    logic      acc_en;
    logic      emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic contrib;
    logic last;
  } dp_sts_t;

endpackage

### design/stereo_pan_gain_mixer.sv
// Top level of the equal-power pan stereo mixer.
// Each input beat carries one source of the current output frame. For a present, unmuted source
// the next beat is not accepted until both channels are done: one shared
// 20x16 multiplier applies the pan, source, volume and master gains one per cycle, four stages
// for each channel, after one registered read of the sine table per channel. An absent or
// muted source skips the table reads and gain stages.
// The beat marked last_source also moves the left, right and mono mix into the output
// register and clears the accumulators; it waits only if the previous result is still
// untaken. The master gain register resets to unity and is written whenever cfg_wr_en is high.
module stereo_pan_gain_mixer #(
  parameter int PAN_TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  spgm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output spgm_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);
  import spgm_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  spgm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spgm_datapath #(
    .PAN_TABLE_DEPTH(PAN_TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

  // A result is only produced for a frame end and never over an untaken one.
  a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.last && (!out_valid || out_ready))
    else $error("result emitted without a frame end or over a pending result");

  // Absent and muted sources never touch the accumulators.
  a_acc_contrib: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_en |-> sts.contrib)
    else $error("accumulator updated for a non-contributing source");

  // A source is worked on alone: no second beat is taken right after one.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a source is in progress");

  // A newly shown result is preceded by its emit command.
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid without an emit");

endmodule

### design/spgm_pan_rom.sv
// Quarter-wave sine table for the equal-power pan gains, registered read.
module spgm_pan_rom #(
  parameter int PAN_TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic [$clog2(PAN_TABLE_DEPTH+1)-1:0] rd_addr,
  output logic [15:0]                          rd_data
);
  import spgm_pkg::*;

  // Integer Taylor series of sin in Q30 through the x^13 term, rounded to Q15.
  function automatic logic [15:0] pan_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] s;
    x    = (64'(k) * HALF_PI_Q30) / 64'(PAN_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = ((x * x2) >> 30) / 64'd6;
    sum  = x - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    s    = (sum + 64'd16384) >> 15;
    return (s > 64'(PAN_GAIN_MAX)) ? PAN_GAIN_MAX : s[15:0];
  endfunction

  logic [15:0] rom_w [PAN_TABLE_DEPTH+1];
  logic [15:0] data_r;

  for (genvar g = 0; g <= PAN_TABLE_DEPTH; g++) begin : g_rom
    assign rom_w[g] = pan_entry(g);
  end

  always_ff @(posedge clk) begin
    data_r <= rom_w[rd_addr];
  end

  assign rd_data = data_r;

endmodule

### design/spgm_datapath.sv
// Datapath: item register, pan index, shared gain multiplier, accumulators, output register.
module spgm_datapath #(
  parameter int PAN_TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spgm_pkg::in_item_t  in_data,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  spgm_pkg::ctl_cmd_t  cmd,
  output spgm_pkg::dp_sts_t   sts,
  output spgm_pkg::out_item_t out_data
);
  import spgm_pkg::*;

  localparam int IDX_W     = $clog2(PAN_TABLE_DEPTH + 1);
  localparam int IDX_SUM_W = IDX_W + 17;

  in_item_t                   item_r;
  logic [GAIN_W-1:0]          master_r;
  logic [IDX_W-1:0]           idx_r;
  logic [MAG_W-1:0]           m_r;
  logic signed [SAMPLE_W-1:0] acc_left_r;
  logic signed [SAMPLE_W-1:0] acc_right_r;
  out_item_t                  out_r;

  logic [IDX_SUM_W-1:0]       idx_sum;
  logic [IDX_W-1:0]           rom_addr;
  logic [15:0]                rom_data;
  logic [SAMPLE_W-1:0]        sample_mag;
  logic [GAIN_W-1:0]          gain;
  logic [PROD_W-1:0]          prod;
  logic [MAG_W-1:0]           m_nxt;
  logic signed [MAG_W:0]      term;
  logic signed [MAG_W+1:0]    acc_sum;
  logic signed [SAMPLE_W-1:0] acc_sel;
  logic signed [SAMPLE_W-1:0] acc_nxt;
  logic signed [SAMPLE_W:0]   lr_sum;
  logic signed [SAMPLE_W:0]   lr_adj;

  assign sts.contrib = item_r.sample_present & ~item_r.source_muted;
  assign sts.last    = item_r.last_source;

  // Offset-binary pan times the table depth, rounded to the nearest entry.
  assign idx_sum = IDX_SUM_W'({~item_r.pan_position[SAMPLE_W-1],
                               item_r.pan_position[SAMPLE_W-2:0]})
                 * IDX_SUM_W'(PAN_TABLE_DEPTH) + IDX_SUM_W'(32768);

  assign rom_addr = (cmd.chan == CH_LEFT) ? IDX_W'(PAN_TABLE_DEPTH) - idx_r : idx_r;

  spgm_pan_rom #(
    .PAN_TABLE_DEPTH(PAN_TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  assign sample_mag = item_r.sample_value[SAMPLE_W-1] ? SAMPLE_W'(-item_r.sample_value)
                                                      : SAMPLE_W'(item_r.sample_value);

  always_comb begin
    unique case (cmd.mul_step)
      STEP_PAN: gain = rom_data;
      STEP_SRC: gain = item_r.source_gain;
      STEP_VOL: gain = item_r.source_volume;
      STEP_MST: gain = master_r;
      default:  gain = master_r;
    endcase
  end

  // Scaling works on the magnitude, so the shift truncates toward zero.
  assign prod  = PROD_W'(m_r) * PROD_W'(gain);
  assign m_nxt = (cmd.mul_step == STEP_PAN || cmd.mul_step == STEP_SRC)
               ? prod[MAG_W+14:15] : prod[MAG_W+13:14];

  assign term    = item_r.sample_value[SAMPLE_W-1] ? -$signed({1'b0, m_r})
                                                   : $signed({1'b0, m_r});
  assign acc_sel = (cmd.chan == CH_LEFT) ? acc_left_r : acc_right_r;
  assign acc_sum = (MAG_W+2)'(acc_sel) + (MAG_W+2)'(term);

  always_comb begin
    priority if (acc_sum > (MAG_W+2)'(32767)) begin
      acc_nxt = 16'sh7FFF;
    end else if (acc_sum < -(MAG_W+2)'(32768)) begin
      acc_nxt = 16'sh8000;
    end else begin
      acc_nxt = acc_sum[SAMPLE_W-1:0];
    end
  end

  // Adding the sign bit before halving rounds a negative sum toward zero.
  assign lr_sum = (SAMPLE_W+1)'(acc_left_r) + (SAMPLE_W+1)'(acc_right_r);
  assign lr_adj = lr_sum + (SAMPLE_W+1)'(lr_sum[SAMPLE_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r    <= MASTER_GAIN_RESET;
      acc_left_r  <= '0;
      acc_right_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        master_r <= cfg_wr_data;
      end
      if (cmd.emit) begin
        acc_left_r  <= '0;
        acc_right_r <= '0;
      end else if (cmd.acc_en) begin
        if (cmd.chan == CH_LEFT) begin
          acc_left_r <= acc_nxt;
        end else begin
          acc_right_r <= acc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.calc_idx) begin
      idx_r <= idx_sum[IDX_W+15:16];
    end
    if (cmd.rd_en) begin
      m_r <= MAG_W'(sample_mag);
    end else if (cmd.mul_en) begin
      m_r <= m_nxt;
    end
    if (cmd.emit) begin
      out_r.left_sample  <= acc_left_r;
      out_r.right_sample <= acc_right_r;
      out_r.mono_downmix <= lr_adj[SAMPLE_W:1];
    end
  end

  assign out_data = out_r;

endmodule

### design/spgm_ctrl.sv
// Controller: sequences index, table reads, gain stages and accumulation per source beat.
module spgm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  spgm_pkg::dp_sts_t  sts,
  output spgm_pkg::ctl_cmd_t cmd
);
  import spgm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDX,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  state_t    state_r, state_nxt;
  mul_step_t step_r, step_nxt;
  chan_t     chan_r, chan_nxt;
  logic      out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.chan      = chan_r;
    cmd.mul_step  = step_r;
    cmd.load_item = in_valid && in_ready;
    cmd.calc_idx  = (state_r == ST_IDX);
    cmd.rd_en     = (state_r == ST_RD);
    cmd.mul_en    = (state_r == ST_MUL);
    cmd.acc_en    = (state_r == ST_ACC);
    cmd.emit      = (state_r == ST_FIN) && sts.last && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    chan_nxt      = chan_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_IDX;
        end
      end
      ST_IDX: begin
        chan_nxt  = CH_LEFT;
        state_nxt = sts.contrib ? ST_RD : ST_FIN;
      end
      ST_RD: begin
        step_nxt  = STEP_PAN;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        unique case (step_r)
          STEP_PAN: step_nxt = STEP_SRC;
          STEP_SRC: step_nxt = STEP_VOL;
          STEP_VOL: step_nxt = STEP_MST;
          STEP_MST: state_nxt = ST_ACC;
          default:  state_nxt = ST_ACC;
        endcase
      end
      ST_ACC: begin
        if (chan_r == CH_LEFT) begin
          chan_nxt  = CH_RIGHT;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // A frame end waits here until the output register is free.
        if (!sts.last) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_PAN;
      chan_r      <= CH_LEFT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
